### hw/rtl/chpt_pkg.sv
// Shared types, codes and the palette ROM for the color histogram table.
// Used by every module of the block; depends on nothing.
package chpt_pkg;

  // Default sizes handed to the top level parameters
  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int COUNT_BITS_DEF    = 16;

  // Fixed widths of the word fields
  localparam int COLOR_W    = 24;
  localparam int SLOT_W     = 5;
  localparam int SLOT_IDX_W = 6;   // covers the largest table of 36 slots
  localparam int OUT_CNT_W  = 16;
  localparam int PALETTE_SIZE = 36;

  // Item kinds
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_COUNTED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_EMPTY = 3'd3,
    ST_READ_VALID = 3'd4
  } status_t;

  // Word that travels down the row of cells
  typedef struct packed {
    logic                  valid;
    logic                  kind;
    logic [COLOR_W-1:0]    color;
    logic [SLOT_W-1:0]     read_slot;
    logic                  done;
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic [OUT_CNT_W-1:0]  count;
  } tok_t;

  // Palette color assigned to a slot index
  function automatic logic [COLOR_W-1:0] palette_color(input logic [SLOT_IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      6'd0:  c = {8'd0,   8'd0,   8'd0};
      6'd1:  c = {8'd255, 8'd255, 8'd255};
      6'd2:  c = {8'd255, 8'd0,   8'd0};
      6'd3:  c = {8'd0,   8'd255, 8'd0};
      6'd4:  c = {8'd0,   8'd0,   8'd255};
      6'd5:  c = {8'd255, 8'd255, 8'd0};
      6'd6:  c = {8'd0,   8'd255, 8'd255};
      6'd7:  c = {8'd255, 8'd0,   8'd255};
      6'd8:  c = {8'd0,   8'd0,   8'd127};
      6'd9:  c = {8'd0,   8'd127, 8'd0};
      6'd10: c = {8'd0,   8'd127, 8'd127};
      6'd11: c = {8'd127, 8'd0,   8'd0};
      6'd12: c = {8'd127, 8'd0,   8'd127};
      6'd13: c = {8'd127, 8'd127, 8'd0};
      6'd14: c = {8'd127, 8'd127, 8'd127};
      6'd15: c = {8'd255, 8'd255, 8'd127};
      6'd16: c = {8'd255, 8'd127, 8'd255};
      6'd17: c = {8'd255, 8'd127, 8'd127};
      6'd18: c = {8'd127, 8'd255, 8'd255};
      6'd19: c = {8'd127, 8'd255, 8'd127};
      6'd20: c = {8'd127, 8'd127, 8'd255};
      6'd21: c = {8'd127, 8'd127, 8'd127};
      6'd22: c = {8'd255, 8'd255, 8'd63};
      6'd23: c = {8'd255, 8'd63,  8'd255};
      6'd24: c = {8'd255, 8'd63,  8'd63};
      6'd25: c = {8'd63,  8'd255, 8'd255};
      6'd26: c = {8'd63,  8'd255, 8'd63};
      6'd27: c = {8'd63,  8'd63,  8'd255};
      6'd28: c = {8'd63,  8'd63,  8'd63};
      6'd29: c = {8'd127, 8'd127, 8'd63};
      6'd30: c = {8'd127, 8'd63,  8'd127};
      6'd31: c = {8'd127, 8'd63,  8'd63};
      6'd32: c = {8'd63,  8'd127, 8'd127};
      6'd33: c = {8'd63,  8'd127, 8'd63};
      6'd34: c = {8'd63,  8'd63,  8'd127};
      6'd35: c = {8'd63,  8'd63,  8'd127};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/chpt_cell.sv
// One table slot: valid bit, color and saturating count, plus one stage of the word row.
// Depends on chpt_pkg.
module chpt_cell import chpt_pkg::*; #(
  parameter int CELL_IDX   = 0,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_IDX);

  logic                  valid_r, valid_nxt;
  logic [COLOR_W-1:0]    color_r, color_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  tok_t                  tok_r, tok_nxt;
  logic                  hit;
  logic                  sel;

  // Match, insert or read against this slot
  always_comb begin
    hit       = valid_r && (color_r == tok_i.color);
    sel       = (SLOT_IDX_W'(tok_i.read_slot) == MY_IDX);
    valid_nxt = valid_r;
    color_nxt = color_r;
    count_nxt = count_r;
    tok_nxt   = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (tok_i.kind == KIND_COUNT) begin
        if (hit) begin
          if (count_r != '1) begin
            count_nxt = count_r + COUNT_BITS'(1);
          end
          tok_nxt.done     = 1'b1;
          tok_nxt.status   = ST_COUNTED;
          tok_nxt.slot_idx = MY_IDX;
          tok_nxt.count    = OUT_CNT_W'(count_nxt);
        end else if (!valid_r) begin
          valid_nxt        = 1'b1;
          color_nxt        = tok_i.color;
          count_nxt        = COUNT_BITS'(1);
          tok_nxt.done     = 1'b1;
          tok_nxt.status   = ST_INSERTED;
          tok_nxt.slot_idx = MY_IDX;
          tok_nxt.count    = OUT_CNT_W'(1);
        end
      end else if (sel && valid_r) begin
        tok_nxt.done     = 1'b1;
        tok_nxt.status   = ST_READ_VALID;
        tok_nxt.slot_idx = MY_IDX;
        tok_nxt.color    = color_r;
        tok_nxt.count    = OUT_CNT_W'(count_r);
      end
    end
  end

  // Hold slot state and pass the word on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Color needs no reset: it is only compared or read while valid
  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign tok_o = tok_r;

endmodule

### hw/rtl/color_histogram_palette_table_core.sv
// A word walks the row of slot cells, one cell per cycle, and is registered in each cell in turn;
// out_valid is high while the word is held in the last cell.
// Only one word is in flight: start is not taken while busy, and is taken again in the
// cycle its result is shown.
// Results hold for one cycle only; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass.
module color_histogram_palette_table_core import chpt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  input  logic [4:0]  in_read_slot,
  output logic        out_valid,
  output logic [4:0]  out_slot,
  output logic [2:0]  out_status,
  output logic [15:0] out_color_count,
  output logic [7:0]  out_stored_red,
  output logic [7:0]  out_stored_green,
  output logic [7:0]  out_stored_blue,
  output logic [7:0]  out_palette_red,
  output logic [7:0]  out_palette_green,
  output logic [7:0]  out_palette_blue
);

  logic               accept;
  logic               busy_r, busy_nxt;
  tok_t               in_tok;
  tok_t               last;
  tok_t               cell_in [TABLE_ENTRIES];
  tok_t               cell_out[TABLE_ENTRIES];
  logic [COLOR_W-1:0] pal;

  assign accept = start && !busy;

  // Build the incoming word
  always_comb begin
    in_tok           = '0;
    in_tok.valid     = accept;
    in_tok.kind      = in_kind;
    in_tok.color     = {in_pixel_red, in_pixel_green, in_pixel_blue};
    in_tok.read_slot = in_read_slot;
    in_tok.status    = ST_FULL;
  end

  // Row of slot cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_in[g] = in_tok;
    end else begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end
    chpt_cell #(
      .CELL_IDX  (g),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .tok_i(cell_in[g]),
      .tok_o(cell_out[g])
    );
  end

  assign last = cell_out[TABLE_ENTRIES-1];

  // Track the word in flight
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (last.valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r && !last.valid;

  // Format the result word leaving the row
  assign pal       = palette_color(last.slot_idx);
  assign out_valid = last.valid;

  always_comb begin
    out_slot          = '0;
    out_status        = 3'(ST_FULL);
    out_color_count   = '0;
    out_stored_red    = '0;
    out_stored_green  = '0;
    out_stored_blue   = '0;
    out_palette_red   = '0;
    out_palette_green = '0;
    out_palette_blue  = '0;
    if (last.done) begin
      out_slot          = last.slot_idx[SLOT_W-1:0];
      out_status        = 3'(last.status);
      out_color_count   = last.count;
      out_stored_red    = last.color[23:16];
      out_stored_green  = last.color[15:8];
      out_stored_blue   = last.color[7:0];
      out_palette_red   = pal[23:16];
      out_palette_green = pal[15:8];
      out_palette_blue  = pal[7:0];
    end else if (last.kind == KIND_READ) begin
      out_slot   = last.read_slot;
      out_status = 3'(ST_READ_EMPTY);
    end
  end

endmodule

### hw/rtl/chpt_checker.sv
// Port-level checks for the color histogram table core, with the bind that attaches them.
// Depends on chpt_pkg and color_histogram_palette_table_core.
module chpt_checker import chpt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [4:0]  out_slot,
  input logic [2:0]  out_status,
  input logic [15:0] out_color_count,
  input logic [7:0]  out_stored_red,
  input logic [7:0]  out_stored_green,
  input logic [7:0]  out_stored_blue,
  input logic [7:0]  out_palette_red,
  input logic [7:0]  out_palette_green,
  input logic [7:0]  out_palette_blue
);

  // Come out of reset idle with no result
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or result right after reset");

  // Release start in the cycle a result is shown
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");

  // Drop a pixel with a clean word
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 3'(ST_FULL) |->
      out_slot == 5'd0 && out_color_count == 16'd0 &&
      out_palette_red == 8'd0 && out_stored_red == 8'd0)
    else $error("dropped pixel word not zero");

  // Report an empty read with zero contents
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 3'(ST_READ_EMPTY) |->
      out_color_count == 16'd0 && out_stored_green == 8'd0 &&
      out_stored_blue == 8'd0 && out_palette_green == 8'd0 && out_palette_blue == 8'd0)
    else $error("empty read word not zero");

  // Start a new slot with a count of one
  a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 3'(ST_INSERTED) |-> out_color_count == 16'd1)
    else $error("inserted slot count not one");

endmodule

bind color_histogram_palette_table_core chpt_checker u_chpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_slot         (out_slot),
  .out_status       (out_status),
  .out_color_count  (out_color_count),
  .out_stored_red   (out_stored_red),
  .out_stored_green (out_stored_green),
  .out_stored_blue  (out_stored_blue),
  .out_palette_red  (out_palette_red),
  .out_palette_green(out_palette_green),
  .out_palette_blue (out_palette_blue)
);
